>>> rtl/rpf_pkg.sv
package rpf_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int SLOT_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int VAL_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int S_DATA_W   = 136;
    localparam int M_DATA_W   = 8;

    localparam logic [2:0] MODE_CMP     = 3'd0;
    localparam logic [2:0] MODE_BETWEEN = 3'd1;
    localparam logic [2:0] MODE_LIST    = 3'd2;
    localparam logic [2:0] MODE_NULL    = 3'd3;
    localparam logic [2:0] MODE_AND     = 3'd4;

    localparam logic [2:0] OP_LT = 3'd0;
    localparam logic [2:0] OP_LE = 3'd1;
    localparam logic [2:0] OP_GT = 3'd2;
    localparam logic [2:0] OP_GE = 3'd3;
    localparam logic [2:0] OP_EQ = 3'd4;
    localparam logic [2:0] OP_NE = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OP_A          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OP_B          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_A       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONST_B       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_COUNT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEST_NOT_NULL = 3'd6;

    typedef struct packed {
        logic              load;
        logic [SLOT_W-1:0] slot;
        logic [VAL_W-1:0]  key_a;
        logic              nan_a;
        logic              null_a;
        logic [VAL_W-1:0]  key_b;
        logic              nan_b;
        logic              null_b;
    } key_t;

    typedef struct packed {
        logic                  null_a;
        logic                  null_b;
        logic                  a_ca_lt;
        logic                  a_ca_eq;
        logic                  a_cb_lt;
        logic                  a_cb_eq;
        logic                  b_cb_lt;
        logic                  b_cb_eq;
        logic [LIST_DEPTH-1:0] hit;
    } cmp_t;

    function automatic logic is_nan(input logic [VAL_W-1:0] x);
        return (x[62:52] == 11'h7ff) && (x[51:0] != '0);
    endfunction

    function automatic logic [VAL_W-1:0] order_key(input logic [VAL_W-1:0] x);
        logic [VAL_W-1:0] z;
        z = (x[62:0] == '0) ? '0 : x;
        return z[63] ? ~z : {1'b1, z[62:0]};
    endfunction

    // {lt, eq} with NaN above everything and NaN equal to NaN
    function automatic logic [1:0] order(input logic [VAL_W-1:0] ka, input logic na,
                                         input logic [VAL_W-1:0] kb, input logic nb);
        logic [1:0] r;
        if (na && nb) begin
            r = 2'b01;
        end else if (na) begin
            r = 2'b00;
        end else if (nb) begin
            r = 2'b10;
        end else begin
            r = {ka < kb, ka == kb};
        end
        return r;
    endfunction

    function automatic logic op_true(input logic [2:0] op, input logic lt, input logic eq);
        logic r;
        case (op)
            OP_LT:   r = lt;
            OP_LE:   r = lt | eq;
            OP_GT:   r = !lt && !eq;
            OP_GE:   r = !lt;
            OP_EQ:   r = eq;
            OP_NE:   r = !eq;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/rpf_key_stage.sv
module rpf_key_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic                       in_kind,
    input  logic [rpf_pkg::VAL_W-1:0]  in_value_a,
    input  logic                       in_null_a,
    input  logic [rpf_pkg::VAL_W-1:0]  in_value_b,
    input  logic                       in_null_b,
    input  logic [rpf_pkg::SLOT_W-1:0] in_list_slot,
    output logic                       key_valid,
    output rpf_pkg::key_t              key_q
);
    import rpf_pkg::*;

    logic valid_reg;
    key_t key_reg;
    key_t key_next;

    always_comb begin
        key_next.load   = in_kind;
        key_next.slot   = in_list_slot;
        key_next.key_a  = order_key(in_value_a);
        key_next.nan_a  = is_nan(in_value_a);
        key_next.null_a = in_null_a;
        key_next.key_b  = order_key(in_value_b);
        key_next.nan_b  = is_nan(in_value_b);
        key_next.null_b = in_null_b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            key_reg <= key_next;
        end
    end

    assign key_valid = valid_reg;
    assign key_q     = key_reg;

endmodule

>>> rtl/rpf_compare_stage.sv
module rpf_compare_stage (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        key_valid,
    input  rpf_pkg::key_t               key_q,
    input  logic [rpf_pkg::VAL_W-1:0]   key_ca,
    input  logic                        nan_ca,
    input  logic [rpf_pkg::VAL_W-1:0]   key_cb,
    input  logic                        nan_cb,
    input  logic [rpf_pkg::COUNT_W-1:0] list_count,
    output logic                        cmp_valid,
    output rpf_pkg::cmp_t               cmp_q
);
    import rpf_pkg::*;

    logic [VAL_W-1:0] list_key_reg [LIST_DEPTH];
    logic             list_nan_reg [LIST_DEPTH];
    logic             valid_reg;
    cmp_t             cmp_reg;
    cmp_t             cmp_next;
    logic [1:0]       o_a_ca;
    logic [1:0]       o_a_cb;
    logic [1:0]       o_b_cb;

    always_comb begin
        o_a_ca = order(key_q.key_a, key_q.nan_a, key_ca, nan_ca);
        o_a_cb = order(key_q.key_a, key_q.nan_a, key_cb, nan_cb);
        o_b_cb = order(key_q.key_b, key_q.nan_b, key_cb, nan_cb);
        cmp_next.null_a  = key_q.null_a;
        cmp_next.null_b  = key_q.null_b;
        cmp_next.a_ca_lt = o_a_ca[1];
        cmp_next.a_ca_eq = o_a_ca[0];
        cmp_next.a_cb_lt = o_a_cb[1];
        cmp_next.a_cb_eq = o_a_cb[0];
        cmp_next.b_cb_lt = o_b_cb[1];
        cmp_next.b_cb_eq = o_b_cb[0];
        for (int i = 0; i < LIST_DEPTH; i++) begin
            cmp_next.hit[i] = (COUNT_W'(i) < list_count) &&
                (key_q.nan_a ? list_nan_reg[i]
                             : (!list_nan_reg[i] && key_q.key_a == list_key_reg[i]));
        end
    end

    // commit list loads in order with the rows around them
    always_ff @(posedge aclk) begin
        if (adv && key_valid && key_q.load) begin
            list_key_reg[key_q.slot] <= key_q.key_a;
            list_nan_reg[key_q.slot] <= key_q.nan_a;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= key_valid && !key_q.load;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cmp_reg <= cmp_next;
        end
    end

    assign cmp_valid = valid_reg;
    assign cmp_q     = cmp_reg;

endmodule

>>> rtl/rpf_match_stage.sv
module rpf_match_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  logic          cmp_valid,
    input  rpf_pkg::cmp_t cmp_q,
    input  logic [2:0]    mode,
    input  logic [2:0]    op_a,
    input  logic [2:0]    op_b,
    input  logic          test_not_null,
    output logic          out_valid,
    output logic          out_match
);
    import rpf_pkg::*;

    logic valid_reg;
    logic match_reg;
    logic match_next;

    always_comb begin
        unique case (mode)
            MODE_CMP:
                match_next = !cmp_q.null_a && op_true(op_a, cmp_q.a_ca_lt, cmp_q.a_ca_eq);
            MODE_BETWEEN:
                match_next = !cmp_q.null_a && op_true(OP_GE, cmp_q.a_ca_lt, cmp_q.a_ca_eq)
                             && op_true(OP_LE, cmp_q.a_cb_lt, cmp_q.a_cb_eq);
            MODE_LIST:
                match_next = !cmp_q.null_a && (|cmp_q.hit);
            MODE_NULL:
                match_next = test_not_null ? !cmp_q.null_a : cmp_q.null_a;
            MODE_AND:
                match_next = !cmp_q.null_a && op_true(op_a, cmp_q.a_ca_lt, cmp_q.a_ca_eq)
                             && !cmp_q.null_b
                             && op_true(op_b, cmp_q.b_cb_lt, cmp_q.b_cb_eq);
            default:
                match_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= cmp_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            match_reg <= match_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_match = match_reg;

endmodule

>>> rtl/row_predicate_filter.sv
// Pipeline: three register stages (key, compare, match) lie between an accepted
// input transaction and its result on m_tdata.
// Throughput: one transaction per cycle; list loads give no result.
// Rate is set by the output register: a stalled result holds all three stages.
// Reset (aresetn low, synchronous) clears valid bits and configuration to zero.
// List entries are undefined until loaded.
module row_predicate_filter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // value_a[63:0], null_a[64], value_b[128:65], null_b[129], list_slot[133:130]
    input  logic [rpf_pkg::S_DATA_W-1:0]   s_tdata,
    // kind[0]
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // match[0]
    output logic [rpf_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rpf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpf_pkg::VAL_W-1:0]      cfg_data
);
    import rpf_pkg::*;

    logic [2:0]         mode_reg;
    logic [2:0]         op_a_reg;
    logic [2:0]         op_b_reg;
    logic [VAL_W-1:0]   const_a_reg;
    logic [VAL_W-1:0]   const_b_reg;
    logic [COUNT_W-1:0] list_count_reg;
    logic               test_not_null_reg;

    logic               adv;
    logic               key_valid;
    key_t               key_q;
    logic               cmp_valid;
    cmp_t               cmp_q;
    logic               out_match;

    assign adv       = !m_tvalid || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= '0;
            op_a_reg          <= '0;
            op_b_reg          <= '0;
            const_a_reg       <= '0;
            const_b_reg       <= '0;
            list_count_reg    <= '0;
            test_not_null_reg <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MODE:          mode_reg          <= cfg_data[2:0];
                REG_OP_A:          op_a_reg          <= cfg_data[2:0];
                REG_OP_B:          op_b_reg          <= cfg_data[2:0];
                REG_CONST_A:       const_a_reg       <= cfg_data;
                REG_CONST_B:       const_b_reg       <= cfg_data;
                REG_LIST_COUNT:    list_count_reg    <= cfg_data[COUNT_W-1:0];
                REG_TEST_NOT_NULL: test_not_null_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    rpf_key_stage u_key (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_valid     (s_tvalid),
        .in_kind      (s_tuser),
        .in_value_a   (s_tdata[63:0]),
        .in_null_a    (s_tdata[64]),
        .in_value_b   (s_tdata[128:65]),
        .in_null_b    (s_tdata[129]),
        .in_list_slot (s_tdata[133:130]),
        .key_valid    (key_valid),
        .key_q        (key_q)
    );

    rpf_compare_stage u_cmp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .key_valid  (key_valid),
        .key_q      (key_q),
        .key_ca     (order_key(const_a_reg)),
        .nan_ca     (is_nan(const_a_reg)),
        .key_cb     (order_key(const_b_reg)),
        .nan_cb     (is_nan(const_b_reg)),
        .list_count (list_count_reg),
        .cmp_valid  (cmp_valid),
        .cmp_q      (cmp_q)
    );

    rpf_match_stage u_match (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .cmp_valid     (cmp_valid),
        .cmp_q         (cmp_q),
        .mode          (mode_reg),
        .op_a          (op_a_reg),
        .op_b          (op_b_reg),
        .test_not_null (test_not_null_reg),
        .out_valid     (m_tvalid),
        .out_match     (out_match)
    );

    assign m_tdata = {{(M_DATA_W-1){1'b0}}, out_match};

endmodule
